// ----- hw/rtl/bsra_pkg.sv -----
// shared types and constants for the banker allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bsra_pkg;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned PID_W = 4;
    localparam int unsigned AMT_W = 8;
    localparam int unsigned ST_W = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned SUM_W = 16;
    localparam int unsigned SW = 18;
    localparam int unsigned NRES_MAX = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_MAX   = 2'd0,
        CMD_LOAD_ALLOC = 2'd1,
        CMD_REQUEST    = 2'd2,
        CMD_RELEASE    = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_ID     = 3'd1,
        ST_OVER_NEED  = 3'd2,
        ST_OVER_AVAIL = 3'd3,
        ST_UNSAFE     = 3'd4,
        ST_OVER_ALLOC = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_ACTIVE = 3'd0,
        CFG_TOTAL0 = 3'd1,
        CFG_TOTAL1 = 3'd2,
        CFG_TOTAL2 = 3'd3,
        CFG_TOTAL3 = 3'd4
    } t_cfg_idx;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_CLEAR  = 8'b00000010,
        S_READ   = 8'b00000100,
        S_EXEC   = 8'b00001000,
        S_WREAD  = 8'b00010000,
        S_WCHK   = 8'b00100000,
        S_UNDO   = 8'b01000000,
        S_OUT    = 8'b10000000
    } t_state;
endpackage
`default_nettype wire

// ----- hw/rtl/banker_safe_resource_allocator.sv -----
// Banker's deadlock-avoidance allocator, top level
// depends on bsra_pkg and bsra_ram
//
// After reset a clearing pass zeroes the process memory; no transaction is
// taken then. Each row (max demand and allocation for every resource) lives
// in one memory word, read in the cycle after its address. Load, release
// and rejected requests go through S_READ, S_EXEC and S_OUT; a bad id goes
// from S_READ straight to S_OUT. An accepted request runs the safety walk:
// each pass reads all active rows one a cycle, up to n passes for n active
// processes, and an unsafe request is rolled back in S_UNDO. One item is in
// work at a time; the result sits in an output register.
`timescale 1ns / 1ps
`default_nettype none
module banker_safe_resource_allocator
    import bsra_pkg::*;
#(
    parameter int unsigned MAX_PROCESSES = 8,
    parameter int unsigned NUM_RESOURCES = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // command[1:0], process_id[5:2], amount_0..amount_3 [37:6], pad [39:38]
    input  wire logic [39:0]           s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status[2:0], avail_0..avail_3 [34:3], pad [39:35]
    output logic [39:0]                m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned AW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned RW = 2 * AMT_W * NUM_RESOURCES;
    localparam int unsigned PCW = $clog2(MAX_PROCESSES + 1);

    // configuration and per-resource state
    logic [3:0] r_active;
    logic [AMT_W-1:0] r_total [NUM_RESOURCES];
    logic [SUM_W-1:0] r_sum [NUM_RESOURCES];
    logic [SW-1:0] r_work [NUM_RESOURCES];
    logic [MAX_PROCESSES-1:0] r_done;

    t_state r_state;
    t_cmd r_cmd;
    logic [PID_W-1:0] r_pid;
    logic [AMT_W-1:0] r_amt [NUM_RESOURCES];
    logic [AW-1:0] r_ptr;
    logic [PCW-1:0] r_fin;
    logic r_progress;
    logic r_undo_rd;
    t_status r_status;
    logic r_ovalid;
    logic [39:0] r_odata;

    // memory port
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0] pid_addr;

    assign pid_addr = AW'(r_pid);

    bsra_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_rows (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    // effective process count
    logic [PCW-1:0] eff;
    always_comb begin
        if ({28'd0, r_active} > MAX_PROCESSES) eff = PCW'(MAX_PROCESSES);
        else eff = PCW'(r_active);
    end

    function automatic logic [SW-1:0] avail_f(input logic [AMT_W-1:0] t,
                                              input logic [SUM_W-1:0] s);
        avail_f = {{(SW-AMT_W){1'b0}}, t} - {{(SW-SUM_W){1'b0}}, s};
    endfunction

    // row fields: max at low half, allocation at high half
    logic [AMT_W-1:0] rd_max [NUM_RESOURCES];
    logic [AMT_W-1:0] rd_alc [NUM_RESOURCES];
    logic [AMT_W-1:0] rd_need [NUM_RESOURCES];
    always_comb begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            rd_max[r] = ram_rdata[r*AMT_W +: AMT_W];
            rd_alc[r] = ram_rdata[(NUM_RESOURCES+r)*AMT_W +: AMT_W];
            rd_need[r] = (rd_max[r] > rd_alc[r]) ? rd_max[r] - rd_alc[r] : '0;
        end
    end

    // available units, floored for the result
    logic [SW-1:0] avail_now [NUM_RESOURCES];
    logic [NRES_MAX*AMT_W-1:0] avail_bus;
    always_comb begin
        avail_bus = '0;
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            avail_now[r] = avail_f(r_total[r], r_sum[r]);
            avail_bus[r*AMT_W +: AMT_W] = avail_now[r][SW-1] ? '0 : avail_now[r][AMT_W-1:0];
        end
    end

    // request checks; the lowest-numbered failing resource sets the status
    t_status req_st;
    logic rel_bad;
    logic can_run;
    always_comb begin
        req_st = ST_OK;
        rel_bad = 1'b0;
        can_run = 1'b1;
        for (int r = NUM_RESOURCES - 1; r >= 0; r--) begin
            if (r_amt[r] > rd_need[r]) req_st = ST_OVER_NEED;
            else if ($signed({10'd0, r_amt[r]}) > $signed(avail_f(r_total[r], r_sum[r])))
                req_st = ST_OVER_AVAIL;
        end
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            if (r_amt[r] > rd_alc[r]) rel_bad = 1'b1;
            if ($signed({10'd0, rd_need[r]}) > $signed(r_work[r])) can_run = 1'b0;
        end
    end

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    logic last_row;
    assign last_row = (PCW'(r_ptr) == eff - PCW'(1));

    // memory control
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = pid_addr;
        ram_wdata = ram_rdata;
        ram_raddr = r_ptr;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = '0;
            end
            S_READ: ram_raddr = pid_addr;
            S_EXEC: begin
                ram_raddr = pid_addr;
                unique case (r_cmd)
                    CMD_LOAD_MAX: begin
                        ram_we = 1'b1;
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            ram_wdata[r*AMT_W +: AMT_W] = r_amt[r];
                    end
                    CMD_LOAD_ALLOC: begin
                        ram_we = 1'b1;
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            ram_wdata[(NUM_RESOURCES+r)*AMT_W +: AMT_W] = r_amt[r];
                    end
                    CMD_REQUEST: begin
                        ram_we = (req_st == ST_OK);
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            ram_wdata[(NUM_RESOURCES+r)*AMT_W +: AMT_W] = rd_alc[r] + r_amt[r];
                    end
                    CMD_RELEASE: begin
                        ram_we = !rel_bad;
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            ram_wdata[(NUM_RESOURCES+r)*AMT_W +: AMT_W] = rd_alc[r] - r_amt[r];
                    end
                    default: ram_we = 1'b0;
                endcase
            end
            S_WREAD: ram_raddr = r_ptr;
            S_WCHK: ram_raddr = last_row ? '0 : r_ptr + AW'(1);
            S_UNDO: begin
                // own row read back, then written with the request taken out
                ram_raddr = pid_addr;
                ram_we = r_undo_rd;
                for (int r = 0; r < NUM_RESOURCES; r++)
                    ram_wdata[(NUM_RESOURCES+r)*AMT_W +: AMT_W] = rd_alc[r] - r_amt[r];
            end
            default: ram_raddr = r_ptr;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr <= '0;
            r_ovalid <= 1'b0;
            r_active <= 4'd8;
            for (int r = 0; r < NUM_RESOURCES; r++) begin
                r_total[r] <= '0;
                r_sum[r] <= '0;
            end
            r_undo_rd <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE: r_active <= i_cfg_data[3:0];
                    CFG_TOTAL0, CFG_TOTAL1, CFG_TOTAL2, CFG_TOTAL3: begin
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            if (i_cfg_index == CFG_IDX_W'(r + 1)) r_total[r] <= i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + AW'(1);
                    if ({{(32-AW){1'b0}}, r_ptr} == MAX_PROCESSES - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd <= t_cmd'(s_axis_tdata[1:0]);
                        r_pid <= s_axis_tdata[5:2];
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            r_amt[r] <= s_axis_tdata[6 + r*AMT_W +: AMT_W];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (32'(r_pid) >= 32'(eff)) begin
                        r_status <= ST_BAD_ID;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_cmd)
                        CMD_LOAD_MAX: begin
                            r_status <= ST_OK;
                            r_state <= S_OUT;
                        end
                        CMD_LOAD_ALLOC: begin
                            r_status <= ST_OK;
                            r_state <= S_OUT;
                            for (int r = 0; r < NUM_RESOURCES; r++)
                                r_sum[r] <= r_sum[r] - SUM_W'(rd_alc[r]) + SUM_W'(r_amt[r]);
                        end
                        CMD_REQUEST: begin
                            if (req_st != ST_OK) begin
                                r_status <= req_st;
                                r_state <= S_OUT;
                            end else begin
                                for (int r = 0; r < NUM_RESOURCES; r++) begin
                                    r_sum[r] <= r_sum[r] + SUM_W'(r_amt[r]);
                                    r_work[r] <= avail_f(r_total[r], r_sum[r])
                                                 - SW'(r_amt[r]);
                                end
                                r_done <= '0;
                                r_fin <= '0;
                                r_progress <= 1'b0;
                                r_ptr <= '0;
                                r_state <= S_WREAD;
                            end
                        end
                        CMD_RELEASE: begin
                            r_state <= S_OUT;
                            if (rel_bad) begin
                                r_status <= ST_OVER_ALLOC;
                            end else begin
                                r_status <= ST_OK;
                                for (int r = 0; r < NUM_RESOURCES; r++)
                                    r_sum[r] <= r_sum[r] - SUM_W'(r_amt[r]);
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_WREAD: r_state <= S_WCHK;
                S_WCHK: begin
                    // one row of the walk per cycle; read of next row in flight
                    logic fin_now;
                    logic [PCW-1:0] fin_n;
                    fin_now = !r_done[r_ptr] && can_run;
                    fin_n = r_fin + (fin_now ? PCW'(1) : PCW'(0));
                    if (fin_now) begin
                        r_done[r_ptr] <= 1'b1;
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            r_work[r] <= r_work[r] + SW'(rd_alc[r]);
                    end
                    r_fin <= fin_n;
                    if (last_row) begin
                        r_ptr <= '0;
                        r_progress <= 1'b0;
                        if (fin_n == eff) begin
                            r_status <= ST_OK;
                            r_state <= S_OUT;
                        end else if (!(r_progress || fin_now)) begin
                            r_status <= ST_UNSAFE;
                            r_undo_rd <= 1'b0;
                            r_state <= S_UNDO;
                        end
                    end else begin
                        r_ptr <= r_ptr + AW'(1);
                        r_progress <= r_progress || fin_now;
                    end
                end
                S_UNDO: begin
                    // roll back: re-read own row, then write it reduced
                    r_undo_rd <= 1'b1;
                    if (r_undo_rd) begin
                        for (int r = 0; r < NUM_RESOURCES; r++)
                            r_sum[r] <= r_sum[r] - SUM_W'(r_amt[r]);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_odata <= {5'd0, avail_bus, r_status};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/bsra_ram.sv -----
// generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module bsra_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/bsra_checker.sv -----
// port-level checks for the banker allocator
// depends on banker_safe_resource_allocator (bind target)
`timescale 1ns / 1ps
`default_nettype none
module bsra_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    // output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // status code in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5)
        else $error("bad status code");
    // one item at a time: no accept while result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("accept while result pending");
    // a transaction is never answered in the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind banker_safe_resource_allocator bsra_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
